/* rtl/bpdt_pkg.sv */
// Package for the bucketed pattern dedup table: sizes, register indexes, request codes.
// No dependencies.
package bpdt_pkg;
	localparam int MAX_SAMPLES   = 256;
	localparam int BUCKET_DEPTH  = 8;
	localparam int PATTERN_WORDS = 4;
	localparam int PAT_W         = 64 * PATTERN_WORDS;
	localparam int KEY_W         = $clog2(MAX_SAMPLES);
	localparam int POS_W         = $clog2(BUCKET_DEPTH);
	localparam int FILL_W        = $clog2(BUCKET_DEPTH + 1);
	localparam int ADDR_W        = KEY_W + POS_W;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 9;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EPB     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORDS   = 2'd2;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  bucket_key;
		logic [63:0] word_0;
		logic [63:0] word_1;
		logic [63:0] word_2;
		logic [63:0] word_3;
	} req_t;

	typedef struct packed {
		logic        matched;
		logic [10:0] slot_index;
		logic        bucket_now_full;
		logic        overflow;
	} rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_t;

	// memory port request from the controller
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [PAT_W-1:0]  wr_data;
	} mem_req_t;
endpackage

/* rtl/bpdt_if.sv */
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on bpdt_pkg.
interface bpdt_req_if import bpdt_pkg::*; (input logic clk);
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bpdt_rsp_if import bpdt_pkg::*; (input logic clk);
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bpdt_cfg_if import bpdt_pkg::*; (input logic clk);
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/bpdt_pat_ram.sv */
// Pattern memory: one write port, one read port, registered read data.
// Depends on bpdt_pkg.
module bpdt_pat_ram import bpdt_pkg::*; (
	input  logic             clk,
	input  mem_req_t         req,
	output logic [PAT_W-1:0] rd_data
);
	logic [PAT_W-1:0] mem [MAX_SAMPLES*BUCKET_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en) rd_data <= mem[req.rd_addr];
	end
endmodule

/* rtl/bpdt_fill_ram.sv */
// Bucket fill counts: memory with read-modify-write and an epoch tag per entry,
// so a clear flips the epoch instead of rewriting entries. Depends on bpdt_pkg.
module bpdt_fill_ram import bpdt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              rd_en,
	input  logic [KEY_W-1:0]  rd_addr,
	output logic [FILL_W-1:0] rd_fill,
	input  logic              wr_en,
	input  logic [KEY_W-1:0]  wr_addr,
	input  logic [FILL_W-1:0] wr_fill
);
	// entry = {epoch, count}; valid count only when epoch matches
	logic [FILL_W:0] mem [MAX_SAMPLES];
	logic [FILL_W:0] rd_q;
	logic            epoch_q;
	logic [MAX_SAMPLES-1:0] touched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= 1'b0;
			touched_q <= '0;
		end else if (clear) begin
			epoch_q   <= ~epoch_q;
			touched_q <= '0;
		end else if (wr_en) begin
			touched_q[wr_addr] <= 1'b1;
		end
	end

	logic valid_q;
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= {epoch_q, wr_fill};
		if (rd_en) begin
			rd_q    <= mem[rd_addr];
			valid_q <= touched_q[rd_addr];
		end
	end

	assign rd_fill = (valid_q && rd_q[FILL_W] == epoch_q) ? rd_q[FILL_W-1:0] : '0;
endmodule

/* rtl/bpdt_ctrl.sv */
// Lookup sequencer: reads fills, scans main then mirror bucket one entry per
// cycle, appends on a miss if the bucket has room. Depends on bpdt_pkg, bpdt_if.
module bpdt_ctrl import bpdt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	bpdt_req_if.sink          req,
	bpdt_rsp_if.source        rsp,
	bpdt_cfg_if.sink          cfg,
	output mem_req_t          mem,
	input  logic [PAT_W-1:0]  pat_rd,
	output logic              fill_clear,
	output logic              fill_rd_en,
	output logic [KEY_W-1:0]  fill_rd_addr,
	input  logic [FILL_W-1:0] fill_rd,
	output logic              fill_wr_en,
	output logic [KEY_W-1:0]  fill_wr_addr,
	output logic [FILL_W-1:0] fill_wr
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_FILL_M, ST_FILL_R, ST_SCAN_M, ST_SCAN_R, ST_RESP
	} state_t;

	state_t state_q;
	logic [8:0]        samples_q;
	logic [3:0]        epb_q;
	logic [2:0]        words_q;
	logic [7:0]        key_q;
	logic [7:0]        mirror_q;
	logic [PAT_W-1:0]  pat_q;
	logic [PAT_W-1:0]  mask_q;
	logic [PAT_W-1:0]  wmask_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] mused_q;
	logic [POS_W:0]    pos_q;
	logic              mir_phase_q;
	logic              chk_q;
	logic [POS_W-1:0]  chk_pos_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	// saturated registers
	logic [FILL_W-1:0] epb;
	logic [2:0]        nw;
	always_comb begin
		epb = (epb_q == 4'd0) ? FILL_W'(1) :
		      (epb_q > 4'(BUCKET_DEPTH)) ? FILL_W'(BUCKET_DEPTH) : FILL_W'(epb_q);
		nw  = (words_q == 3'd0) ? 3'd1 :
		      (words_q > 3'(PATTERN_WORDS)) ? 3'(PATTERN_WORDS) : words_q;
	end

	logic [8:0] limit;
	assign limit = (samples_q < {nw, 6'd0}) ? samples_q : {nw, 6'd0};

	assign cfg.ready = (state_q == ST_IDLE);
	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	logic [FILL_W-1:0] used;
	assign used = (fill_q < epb) ? fill_q : epb;
	logic [FILL_W-1:0] fm_used;
	assign fm_used = (fill_rd < epb) ? fill_rd : epb;

	// compare on registered memory data
	logic hit_exact, hit_comp;
	assign hit_exact = ((pat_rd ^ pat_q) & wmask_q) == '0;
	assign hit_comp  = ((pat_rd ^ ~pat_q) & mask_q) == '0;

	logic [10:0] slot_base;
	logic [7:0]  bk;
	assign bk = mir_phase_q ? mirror_q : key_q;
	assign slot_base = 11'(bk - 8'd1) * 11'(epb);

	logic [FILL_W-1:0] limit_cur;
	assign limit_cur = mir_phase_q ? mused_q : used;

	logic do_write;
	assign do_write = (state_q == ST_RESP) && !rsp_q.matched && !rsp_q.overflow;

	always_comb begin
		mem = '0;
		mem.rd_en   = (state_q == ST_SCAN_M || state_q == ST_SCAN_R) &&
		              (pos_q < (POS_W+1)'(limit_cur));
		mem.rd_addr = {bk, pos_q[POS_W-1:0]};
		mem.wr_en   = do_write;
		mem.wr_addr = {key_q, fill_q[POS_W-1:0]};
		mem.wr_data = pat_q & wmask_q;
		fill_rd_en   = (state_q == ST_IDLE && req.valid && req.ready) ||
		               state_q == ST_FILL_M;
		fill_rd_addr = (state_q == ST_IDLE) ? req.data.bucket_key : mirror_q;
		fill_clear   = req.valid && req.ready && req.data.opcode == OP_CLEAR;
		fill_wr_en   = do_write;
		fill_wr_addr = key_q;
		fill_wr      = fill_q + FILL_W'(1);
	end

	logic [PAT_W-1:0] lmask;
	always_comb begin
		for (int i = 0; i < PAT_W; i++) lmask[i] = (i < limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			samples_q   <= 9'd256;
			epb_q       <= 4'd8;
			words_q     <= 3'd4;
			chk_q       <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					REG_SAMPLES: samples_q <= cfg.data.data;
					REG_EPB:     epb_q     <= cfg.data.data[3:0];
					REG_WORDS:   words_q   <= cfg.data.data[2:0];
					default: ;
				endcase
			end
			chk_q <= mem.rd_en;
			chk_pos_q <= pos_q[POS_W-1:0];
			case (state_q)
				ST_IDLE: if (req.valid && req.ready) begin
					key_q  <= req.data.bucket_key;
					pat_q  <= {req.data.word_3, req.data.word_2, req.data.word_1,
					           req.data.word_0};
					mirror_q <= 8'(samples_q - {1'b0, req.data.bucket_key});
					rsp_q  <= '0;
					if (req.data.opcode == OP_CLEAR) begin
						rsp_valid_q <= 1'b1;
					end else if (req.data.bucket_key == 8'd0 ||
					             {1'b0, req.data.bucket_key} >= samples_q ||
					             (samples_q - {1'b0, req.data.bucket_key}) > 9'd255) begin
						rsp_q.overflow <= 1'b1;
						rsp_valid_q    <= 1'b1;
					end else begin
						state_q <= ST_FILL_M;
					end
				end
				ST_FILL_M: begin
					fill_q <= fill_rd;
					for (int w = 0; w < PATTERN_WORDS; w++)
						wmask_q[w*64 +: 64] <= (w < nw) ? '1 : '0;
					mask_q <= lmask;
					state_q <= ST_FILL_R;
				end
				ST_FILL_R: begin
					mused_q     <= fm_used;
					pos_q       <= '0;
					mir_phase_q <= 1'b0;
					state_q     <= ST_SCAN_M;
				end
				ST_SCAN_M, ST_SCAN_R: begin
					if (chk_q && (mir_phase_q ? hit_comp : hit_exact)) begin
						rsp_q.matched    <= 1'b1;
						rsp_q.slot_index <= slot_base + 11'(chk_pos_q);
						rsp_q.bucket_now_full <= (fill_q >= epb);
						state_q <= ST_RESP;
					end else if (!mem.rd_en && !chk_q) begin
						if (!mir_phase_q) begin
							mir_phase_q <= 1'b1;
							pos_q   <= '0;
							state_q <= ST_SCAN_R;
						end else begin
							state_q <= ST_RESP;
							if (fill_q >= epb) begin
								rsp_q.bucket_now_full <= 1'b1;
								rsp_q.overflow        <= 1'b1;
							end else begin
								rsp_q.slot_index <= 11'(key_q - 8'd1) * 11'(epb) +
								                    11'(fill_q);
								rsp_q.bucket_now_full <= (fill_q + FILL_W'(1) == epb);
							end
						end
					end else if (mem.rd_en) begin
						pos_q <= pos_q + (POS_W+1)'(1);
					end
				end
				ST_RESP: begin
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* rtl/bucketed_pattern_dedup_table.sv */
// Top level of the bucketed pattern dedup table.
// Depends on bpdt_pkg, bpdt_if, bpdt_ctrl, bpdt_pat_ram, bpdt_fill_ram.
//
// Each lookup request searches its key's bucket for an exact copy of the
// pattern, then the mirror bucket (sample_count - key) for its complement
// over the active sample bits, and appends the pattern on a miss if the
// bucket has room. Patterns live in one single-port-read memory scanned one
// entry per cycle; a lookup reads the fill counts of the main and mirror
// buckets, scans the entries of each, and answers from a response state;
// out-of-range keys and clear requests are answered from the idle state.
// Bucket fill counts sit in a small memory tagged with an epoch, so a clear
// takes effect at once, with no clearing pass. One request is in flight at
// a time; the result sits in an output register, and a new request is taken
// once it has been delivered. Configuration is taken while idle.
module bucketed_pattern_dedup_table import bpdt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bpdt_req_if.sink   req,
	bpdt_rsp_if.source rsp,
	bpdt_cfg_if.sink   cfg
);
	mem_req_t          mem;
	logic [PAT_W-1:0]  pat_rd;
	logic              fill_clear, fill_rd_en, fill_wr_en;
	logic [KEY_W-1:0]  fill_rd_addr, fill_wr_addr;
	logic [FILL_W-1:0] fill_rd, fill_wr;

	bpdt_ctrl u_ctrl (
		.clk, .arst_n, .req, .rsp, .cfg, .mem, .pat_rd,
		.fill_clear, .fill_rd_en, .fill_rd_addr, .fill_rd,
		.fill_wr_en, .fill_wr_addr, .fill_wr
	);

	bpdt_pat_ram u_pat (.clk, .req(mem), .rd_data(pat_rd));

	bpdt_fill_ram u_fill (
		.clk, .arst_n, .clear(fill_clear), .rd_en(fill_rd_en),
		.rd_addr(fill_rd_addr), .rd_fill(fill_rd), .wr_en(fill_wr_en),
		.wr_addr(fill_wr_addr), .wr_fill(fill_wr)
	);
endmodule

/* rtl/bpdt_checker.sv */
// Port-level checker for the dedup table, bound to the top level.
// Depends on bpdt_pkg and bpdt_if.
module bpdt_checker import bpdt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");
	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while result pending");
	a_ovf_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.overflow |-> !rsp_data.matched)
		else $error("overflow with match");
endmodule

bind bucketed_pattern_dedup_table bpdt_checker u_chk (
	.clk, .arst_n, .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

/* verif/tb_bucketed_pattern_dedup_table.sv */
// Self-checking bench for the bucketed pattern dedup table: predicts every result
// from its own copy of bucket fills and stored patterns. Depends on bpdt_pkg, bpdt_if.
module tb_bucketed_pattern_dedup_table;
	import bpdt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 400000;

	logic clk;
	logic arst_n;

	bpdt_req_if req_ch (clk);
	bpdt_rsp_if rsp_ch (clk);
	bpdt_cfg_if cfg_ch (clk);

	bucketed_pattern_dedup_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// predictor state: register copies, fill per bucket, stored patterns
	logic [8:0]   samples_q;
	logic [3:0]   epb_q;
	logic [2:0]   words_q;
	int           fill_tbl [256];
	logic [255:0] pat_tbl [256][8];

	rsp_t  pending_rsp[$];
	int    fail_cnt;
	int    cyc;
	int    send_idle_pct;
	int    recv_idle_pct;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// cycle counter and run limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random back-pressure, set at the edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result checker, oldest expectation first
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("result with nothing expected: %p", rsp_ch.data);
				fail_cnt++;
			end else begin
				exp_r = pending_rsp.pop_front();
				if (rsp_ch.data.matched !== exp_r.matched) begin
					$error("matched exp %0d got %0d", exp_r.matched, rsp_ch.data.matched);
					fail_cnt++;
				end
				if (rsp_ch.data.slot_index !== exp_r.slot_index) begin
					$error("slot_index exp %0d got %0d", exp_r.slot_index,
						rsp_ch.data.slot_index);
					fail_cnt++;
				end
				if (rsp_ch.data.bucket_now_full !== exp_r.bucket_now_full) begin
					$error("bucket_now_full exp %0d got %0d", exp_r.bucket_now_full,
						rsp_ch.data.bucket_now_full);
					fail_cnt++;
				end
				if (rsp_ch.data.overflow !== exp_r.overflow) begin
					$error("overflow exp %0d got %0d", exp_r.overflow, rsp_ch.data.overflow);
					fail_cnt++;
				end
			end
		end
	end

	// word mask used for exact compare and storage
	function automatic logic [255:0] word_mask(int nw);
		logic [255:0] m;
		m = '0;
		for (int i = 0; i < nw * 64; i++) m[i] = 1'b1;
		return m;
	endfunction

	// expected result of one request; updates the dedup state
	function automatic rsp_t dedup_lookup(req_t r);
		rsp_t         res;
		int           epb, nw, key, mirror, fill, used, mused, lim;
		logic [255:0] pat, wm, cm;
		res = '0;
		if (r.opcode == OP_CLEAR) begin
			foreach (fill_tbl[i]) fill_tbl[i] = 0;
			return res;
		end
		epb = (epb_q < 1) ? 1 : (epb_q > BUCKET_DEPTH ? BUCKET_DEPTH : epb_q);
		nw = (words_q < 1) ? 1 : (words_q > PATTERN_WORDS ? PATTERN_WORDS : words_q);
		pat = {r.word_3, r.word_2, r.word_1, r.word_0};
		key = r.bucket_key;
		if (key == 0 || key >= samples_q) begin
			res.overflow = 1'b1;
			return res;
		end
		mirror = samples_q - key;
		if (mirror > 255) begin
			res.overflow = 1'b1;
			return res;
		end
		wm = word_mask(nw);
		fill = fill_tbl[key];
		used = (fill < epb) ? fill : epb;
		for (int p = 0; p < used; p++) begin
			if ((pat_tbl[key][p] & wm) == (pat & wm)) begin
				res.matched = 1'b1;
				res.slot_index = 11'((key - 1) * epb + p);
				res.bucket_now_full = (fill >= epb);
				return res;
			end
		end
		lim = (samples_q < 64 * nw) ? samples_q : 64 * nw;
		cm = '0;
		for (int i = 0; i < lim; i++) cm[i] = 1'b1;
		mused = (fill_tbl[mirror] < epb) ? fill_tbl[mirror] : epb;
		for (int p = 0; p < mused; p++) begin
			if (((pat_tbl[mirror][p] ^ ~pat) & cm) == '0) begin
				res.matched = 1'b1;
				res.slot_index = 11'((mirror - 1) * epb + p);
				res.bucket_now_full = (fill >= epb);
				return res;
			end
		end
		if (fill >= epb) begin
			res.bucket_now_full = 1'b1;
			res.overflow = 1'b1;
			return res;
		end
		pat_tbl[key][fill] = pat & wm;
		fill_tbl[key] = fill + 1;
		res.slot_index = 11'((key - 1) * epb + fill);
		res.bucket_now_full = (fill + 1 == epb);
		return res;
	endfunction

	// one request: optional idle gap, then hold valid until accepted;
	// valid stays up after acceptance so the next request can follow directly
	task automatic send_req(req_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_rsp.push_back(dedup_lookup(r));
	endtask

	task automatic send_lookup(int key, logic [255:0] pat);
		req_t r;
		r.opcode = OP_LOOKUP;
		r.bucket_key = 8'(key);
		{r.word_3, r.word_2, r.word_1, r.word_0} = pat;
		send_req(r);
	endtask

	task automatic send_clear();
		req_t r;
		r = '0;
		r.opcode = OP_CLEAR;
		r.bucket_key = 8'($urandom);
		r.word_0 = {$urandom, $urandom};
		send_req(r);
	endtask

	// stop sending, wait for every expected result, then let the last lookup settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{index: idx, data: 9'(val)};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_SAMPLES: samples_q = 9'(val);
			REG_EPB:     epb_q = 4'(val);
			REG_WORDS:   words_q = 3'(val);
			default: ;
		endcase
	endtask

	task automatic set_regs(int s, int e, int w);
		drain();
		write_reg(REG_SAMPLES, s);
		write_reg(REG_EPB, e);
		write_reg(REG_WORDS, w);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [255:0] rand_pat();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom};
	endfunction

	// directed: extreme fields, hits both ways, full bucket, bad keys, clear
	task automatic test_directed();
		logic [255:0] p;
		set_regs(256, 8, 4);
		send_lookup(1, '0);
		send_lookup(255, '1);
		send_lookup(1, '0);                  // exact hit
		send_lookup(255, '0);                // complement of all-ones in bucket 255, stored on a miss
		p = rand_pat();
		send_lookup(100, p);
		send_lookup(156, ~p);                // complement hit in mirror
		for (int i = 0; i < 9; i++) send_lookup(7, rand_pat()); // fill, then overflow
		send_lookup(0, p);                   // key zero
		send_lookup(255, p);
		send_clear();
		send_lookup(7, p);
		set_regs(10, 2, 1);
		send_lookup(10, p);                  // key not below sample_count
		send_lookup(3, p);
		send_lookup(7, ~p);                  // compare limited to 10 bits
		set_regs(300, 0, 7);                 // mirror beyond 255, saturated registers
		send_lookup(20, p);
		send_lookup(200, p);
		send_lookup(200, p);
	endtask

	// random phase: small key ranges so buckets fill and hits recur
	task automatic test_random(int n, int s, int e, int w);
		logic [255:0] seen[$];
		logic [255:0] p;
		int k;
		set_regs(s, e, w);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(8) == 0 ? $urandom_range(255) : $urandom_range(1, 6);
			if (k < s && s - k < 256 && k < 256 && $urandom_range(3) == 0 && seen.size() > 0)
			begin
				p = seen[$urandom_range(seen.size() - 1)];
				if ($urandom_range(1)) begin
					p = ~p;
					k = s - k;
					if (k <= 0 || k > 255) k = 1;
				end
			end else begin
				p = rand_pat();
			end
			if ($urandom_range(60) == 0) begin
				send_clear();
			end else begin
				send_lookup(k, p);
				seen.push_back(p);
			end
		end
	endtask

	// exercise the register extremes under load
	task automatic test_config_sweep();
		test_random(150, 256, 8, 4);
		test_random(150, 2, 1, 1);
		test_random(150, 64, 3, 1);
		test_random(150, 130, 15, 2);
		test_random(150, 200, 5, 3);
	endtask

	initial begin
		arst_n = 1'b0;
		cyc = 0;
		fail_cnt = 0;
		send_idle_pct = 22;
		recv_idle_pct = 87;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		samples_q = 9'd256;
		epb_q = 4'd8;
		words_q = 3'd4;
		foreach (fill_tbl[i]) fill_tbl[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		send_idle_pct = 87;
		recv_idle_pct = 22;
		test_random(280, 256, 8, 4);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(300, 40, 4, 4);
		drain();
		if (fail_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

/* files.f */
rtl/bpdt_pkg.sv
rtl/bpdt_if.sv
rtl/bpdt_pat_ram.sv
rtl/bpdt_fill_ram.sv
rtl/bpdt_ctrl.sv
rtl/bucketed_pattern_dedup_table.sv
rtl/bpdt_checker.sv
verif/tb_bucketed_pattern_dedup_table.sv
